// ===== hw/rtl/obm_pkg.sv =====
`timescale 1ns / 1ps
package obm_pkg;

  localparam int unsigned PriceW = 48;
  localparam int unsigned AmtW   = 48;
  localparam int unsigned ProdW  = 8;
  localparam int unsigned TimeW  = 16;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdMatch  = 2'd1,
    CmdClear  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StPick,
    StScan,
    StEmit,
    StNone
  } state_e;

  // one order as it travels along the chain
  typedef struct packed {
    logic              side;
    logic [PriceW-1:0] price;
    logic [AmtW-1:0]   amount;
    logic [ProdW-1:0]  prod;
    logic [TimeW-1:0]  tim;
  } order_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/obm_if.sv =====
`timescale 1ns / 1ps
interface obm_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic                         side;
  logic [obm_pkg::PriceW-1:0]   price;
  logic [obm_pkg::AmtW-1:0]     amount;
  logic [obm_pkg::ProdW-1:0]    product_id;
  logic [obm_pkg::TimeW-1:0]    time_id;
  modport source (output valid, command, side, price, amount, product_id, time_id,
                  input ready);
  modport sink (input valid, command, side, price, amount, product_id, time_id,
                output ready);
endinterface

interface obm_sale_if;
  logic                         valid;
  logic                         ready;
  logic                         sale_valid;
  logic [obm_pkg::PriceW-1:0]   sale_price;
  logic [obm_pkg::AmtW-1:0]     sale_amount;
  logic [obm_pkg::ProdW-1:0]    sale_product;
  logic [obm_pkg::TimeW-1:0]    sale_time;
  logic                         last_sale;
  logic                         overflow;
  modport source (output valid, sale_valid, sale_price, sale_amount, sale_product,
                  sale_time, last_sale, overflow, input ready);
  modport sink (input valid, sale_valid, sale_price, sale_amount, sale_product,
                sale_time, last_sale, overflow, output ready);
endinterface

// ===== hw/rtl/obm_cell.sv =====
`timescale 1ns / 1ps
// one table slot: holds an order with its working amount and pick mark,
// and hands all of it to the next slot on every shift
module obm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  obm_pkg::cell_ctrl_t         ctrl_i,
  input  obm_pkg::order_t             order_i,
  input  logic                        valid_i,
  input  logic [obm_pkg::AmtW-1:0]    rem_i,
  input  logic                        used_i,
  output obm_pkg::order_t             order_o,
  output logic                        valid_o,
  output logic [obm_pkg::AmtW-1:0]    rem_o,
  output logic                        used_o
);

  obm_pkg::order_t            order_q;
  logic                       valid_q;
  logic [obm_pkg::AmtW-1:0]   rem_q;
  logic                       used_q;

  // slot contents move on every shift, by an insert or by the rotation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      order_q <= order_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  // working amount and pick mark, loaded at match start, rotated with the order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      rem_q  <= '0;
    end else if (ctrl_i.load) begin
      used_q <= 1'b0;
      rem_q  <= order_q.amount;
    end else if (ctrl_i.shift) begin
      used_q <= used_i;
      rem_q  <= rem_i;
    end
  end

  assign order_o = order_q;
  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign used_o  = used_q;

endmodule

// ===== hw/rtl/order_book_ask_bid_matcher_unit.sv =====
`timescale 1ns / 1ps
// Order book matcher built as a ring of ORDER_SLOTS cells, each holding one
// order. An insert, a clear or an unused command is taken while the block is
// idle, and the block stays ready; an insert shifts the ring by one so that
// slot 0 holds the newest order, or sets the overflow flag if all slots are
// full. A match first loads the working amounts, then walks the ring in full
// passes while the cells hand their orders around: one pass per ask to pick
// the cheapest unmatched ask plus a final pass that finds none, one pass per
// sale to find the best bid with amount left, and one more pass for each ask
// that the bids cannot fill. Each sale word is held back until the next sale
// or the end of the match is known, so that the last one can be marked, and
// sits on the output until taken. A match with no sale sends one word with no
// sale, marked last. No command is taken while a match runs, and the passes
// stop while a word waits. Stores need no clearing.
module order_book_ask_bid_matcher_unit #(
  parameter int unsigned ORDER_SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  obm_cmd_if.sink      cmd_i,
  obm_sale_if.source   sale_o
);
  localparam int unsigned IdxW = $clog2(ORDER_SLOTS);
  localparam int unsigned CntW = $clog2(ORDER_SLOTS + 1);

  obm_pkg::cell_ctrl_t          ctrl;
  obm_pkg::order_t              ord     [ORDER_SLOTS];
  logic                         vld     [ORDER_SLOTS];
  logic [obm_pkg::AmtW-1:0]     rem     [ORDER_SLOTS];
  logic                         used    [ORDER_SLOTS];
  obm_pkg::order_t              ord_in  [ORDER_SLOTS];
  logic                         vld_in  [ORDER_SLOTS];
  logic [obm_pkg::AmtW-1:0]     rem_in  [ORDER_SLOTS];
  logic                         used_in [ORDER_SLOTS];
  obm_pkg::order_t              ins_ord;

  obm_pkg::state_e              state_q, state_d;
  logic [CntW-1:0]              count_q;
  logic                         ovf_q;
  logic [IdxW-1:0]              step_q;
  logic [obm_pkg::ProdW-1:0]    mprod_q;
  logic [obm_pkg::TimeW-1:0]    mtime_q;
  // ask under matching
  logic                         a_fnd_q;
  logic [IdxW-1:0]              a_step_q;
  logic [obm_pkg::PriceW-1:0]   a_price_q;
  logic [obm_pkg::AmtW-1:0]     a_rem_q;
  // best bid seen in the scan
  logic                         b_fnd_q;
  logic [IdxW-1:0]              b_step_q;
  logic [obm_pkg::PriceW-1:0]   b_price_q;
  logic [obm_pkg::AmtW-1:0]     b_rem_q;
  // sale held back until its last flag is known
  logic                         pend_v_q;
  logic [obm_pkg::PriceW-1:0]   pend_price_q;
  logic [obm_pkg::AmtW-1:0]     pend_amt_q;
  logic                         fin_q;
  // updates applied to a slot as it passes the head
  logic                         tk_v_q;
  logic [IdxW-1:0]              tk_step_q;
  logic [obm_pkg::AmtW-1:0]     tk_amt_q;
  logic                         mk_v_q;
  logic [IdxW-1:0]              mk_step_q;

  // head cell: the one read at this rotation step
  obm_pkg::order_t              h_ord;
  logic                         h_vld, h_used, h_grp, h_used_eff;
  logic [obm_pkg::AmtW-1:0]     h_rem, h_rem_eff;
  logic                         tk_here, mk_here;
  logic                         a_hit, a_fnd_d;
  logic [IdxW-1:0]              a_step_d;
  logic                         b_hit, b_fnd_d;
  logic [IdxW-1:0]              b_step_d;
  logic [obm_pkg::AmtW-1:0]     b_rem_d;
  logic                         ask_done, commit;
  logic [obm_pkg::AmtW-1:0]     sale_amt;
  logic                         last_step, in_fire, out_fire, rotate;

  assign h_ord  = ord[ORDER_SLOTS-1];
  assign h_vld  = vld[ORDER_SLOTS-1];
  assign h_rem  = rem[ORDER_SLOTS-1];
  assign h_used = used[ORDER_SLOTS-1];
  assign h_grp  = h_vld && h_ord.prod == mprod_q && h_ord.tim == mtime_q;
  assign last_step = step_q == IdxW'(ORDER_SLOTS - 1);
  assign in_fire  = cmd_i.valid && cmd_i.ready;
  assign out_fire = sale_o.valid && sale_o.ready;
  assign rotate = (state_q == obm_pkg::StPick) || (state_q == obm_pkg::StScan);

  // pending bid take and ask mark land on the head as it wraps
  assign tk_here    = tk_v_q && step_q == tk_step_q;
  assign mk_here    = mk_v_q && step_q == mk_step_q;
  assign h_rem_eff  = tk_here ? h_rem - tk_amt_q : h_rem;
  assign h_used_eff = h_used || mk_here;

  // ring of cells: slot 0 takes a new order or the wrapped head
  assign ins_ord = '{side: cmd_i.side, price: cmd_i.price, amount: cmd_i.amount,
                     prod: cmd_i.product_id, tim: cmd_i.time_id};
  always_comb begin
    ord_in[0]  = rotate ? h_ord : ins_ord;
    vld_in[0]  = rotate ? h_vld : 1'b1;
    rem_in[0]  = rotate ? h_rem_eff : '0;
    used_in[0] = rotate ? h_used_eff : 1'b0;
    for (int i = 1; i < ORDER_SLOTS; i++) begin
      ord_in[i]  = ord[i-1];
      vld_in[i]  = vld[i-1];
      rem_in[i]  = rem[i-1];
      used_in[i] = used[i-1];
    end
  end

  for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
    obm_cell u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl),
      .order_i(ord_in[g]), .valid_i(vld_in[g]), .rem_i(rem_in[g]), .used_i(used_in[g]),
      .order_o(ord[g]), .valid_o(vld[g]), .rem_o(rem[g]), .used_o(used[g]));
  end

  // cheapest unmatched ask, earliest load on ties
  assign a_hit = state_q == obm_pkg::StPick && h_grp && !h_ord.side && !h_used_eff &&
                 (!a_fnd_q || h_ord.price < a_price_q);
  assign a_fnd_d  = a_fnd_q || a_hit;
  assign a_step_d = a_hit ? step_q : a_step_q;

  // highest bid at or above the ask with amount left, earliest load on ties
  assign b_hit = state_q == obm_pkg::StScan && h_grp && h_ord.side && h_rem_eff != '0 &&
                 h_ord.price >= a_price_q && (!b_fnd_q || h_ord.price > b_price_q);
  assign b_fnd_d  = b_fnd_q || b_hit;
  assign b_step_d = b_hit ? step_q : b_step_q;
  assign b_rem_d  = b_hit ? h_rem_eff : b_rem_q;

  // sale of the current ask against the chosen bid
  assign ask_done = b_rem_d >= a_rem_q;
  assign sale_amt = ask_done ? a_rem_q : b_rem_d;
  assign commit   = (state_q == obm_pkg::StScan && last_step && b_fnd_d && !pend_v_q) ||
                    (state_q == obm_pkg::StEmit && out_fire && !fin_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      obm_pkg::StIdle: begin
        if (in_fire && cmd_i.command == obm_pkg::CmdMatch) state_d = obm_pkg::StLoad;
      end
      obm_pkg::StLoad: state_d = obm_pkg::StPick;
      obm_pkg::StPick: begin
        if (last_step) begin
          if (a_fnd_d) state_d = obm_pkg::StScan;
          else if (pend_v_q) state_d = obm_pkg::StEmit;
          else state_d = obm_pkg::StNone;
        end
      end
      obm_pkg::StScan: begin
        if (last_step) begin
          if (!b_fnd_d) state_d = obm_pkg::StPick;
          else if (pend_v_q) state_d = obm_pkg::StEmit;
          else state_d = ask_done ? obm_pkg::StPick : obm_pkg::StScan;
        end
      end
      obm_pkg::StEmit: begin
        if (out_fire) begin
          if (fin_q) state_d = obm_pkg::StIdle;
          else state_d = ask_done ? obm_pkg::StPick : obm_pkg::StScan;
        end
      end
      obm_pkg::StNone: begin
        if (out_fire) state_d = obm_pkg::StIdle;
      end
      default: state_d = obm_pkg::StIdle;
    endcase
  end

  // outputs and cell control
  always_comb begin
    ctrl.clear = in_fire && cmd_i.command == obm_pkg::CmdClear;
    ctrl.shift = rotate ||
                 (in_fire && cmd_i.command == obm_pkg::CmdInsert &&
                  count_q != CntW'(ORDER_SLOTS));
    ctrl.load  = state_q == obm_pkg::StLoad;
    cmd_i.ready         = state_q == obm_pkg::StIdle;
    sale_o.valid        = state_q == obm_pkg::StEmit || state_q == obm_pkg::StNone;
    sale_o.sale_valid   = state_q == obm_pkg::StEmit;
    sale_o.sale_price   = state_q == obm_pkg::StEmit ? pend_price_q : '0;
    sale_o.sale_amount  = state_q == obm_pkg::StEmit ? pend_amt_q : '0;
    sale_o.sale_product = mprod_q;
    sale_o.sale_time    = mtime_q;
    sale_o.last_sale    = (state_q == obm_pkg::StEmit && fin_q) ||
                          state_q == obm_pkg::StNone;
    sale_o.overflow     = ovf_q;
  end

  // datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= obm_pkg::StIdle;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      step_q       <= '0;
      mprod_q      <= '0;
      mtime_q      <= '0;
      a_fnd_q      <= 1'b0;
      a_step_q     <= '0;
      a_price_q    <= '0;
      a_rem_q      <= '0;
      b_fnd_q      <= 1'b0;
      b_step_q     <= '0;
      b_price_q    <= '0;
      b_rem_q      <= '0;
      pend_v_q     <= 1'b0;
      pend_price_q <= '0;
      pend_amt_q   <= '0;
      fin_q        <= 1'b0;
      tk_v_q       <= 1'b0;
      tk_step_q    <= '0;
      tk_amt_q     <= '0;
      mk_v_q       <= 1'b0;
      mk_step_q    <= '0;
    end else begin
      state_q <= state_d;
      // pass position and updates consumed at the head
      if (rotate) begin
        step_q <= last_step ? '0 : step_q + 1'b1;
        if (tk_here) tk_v_q <= 1'b0;
        if (mk_here) mk_v_q <= 1'b0;
      end
      case (state_q)
        obm_pkg::StIdle: begin
          if (in_fire) begin
            case (cmd_i.command)
              obm_pkg::CmdInsert: begin
                if (count_q == CntW'(ORDER_SLOTS)) ovf_q <= 1'b1;
                else count_q <= count_q + 1'b1;
              end
              obm_pkg::CmdClear: begin
                count_q <= '0;
                ovf_q   <= 1'b0;
              end
              obm_pkg::CmdMatch: begin
                mprod_q <= cmd_i.product_id;
                mtime_q <= cmd_i.time_id;
              end
              default: ;
            endcase
          end
        end
        obm_pkg::StPick: begin
          if (a_hit) begin
            a_fnd_q   <= 1'b1;
            a_step_q  <= step_q;
            a_price_q <= h_ord.price;
            a_rem_q   <= h_ord.amount;
          end
          if (last_step) begin
            a_fnd_q <= 1'b0;
            fin_q   <= 1'b1;
            if (a_fnd_d) begin
              mk_v_q    <= 1'b1;
              mk_step_q <= a_step_d;
            end
          end
        end
        obm_pkg::StScan: begin
          if (b_hit) begin
            b_fnd_q   <= 1'b1;
            b_step_q  <= step_q;
            b_price_q <= h_ord.price;
            b_rem_q   <= h_rem_eff;
          end
          if (last_step) begin
            b_fnd_q <= 1'b0;
            fin_q   <= 1'b0;
          end
        end
        obm_pkg::StEmit: begin
          if (out_fire && fin_q) pend_v_q <= 1'b0;
        end
        default: ;
      endcase
      // a new sale replaces the held one and updates the bid on the next pass
      if (commit) begin
        pend_v_q     <= 1'b1;
        pend_price_q <= a_price_q;
        pend_amt_q   <= sale_amt;
        a_rem_q      <= a_rem_q - sale_amt;
        tk_v_q       <= 1'b1;
        tk_step_q    <= b_step_d;
        tk_amt_q     <= sale_amt;
      end
    end
  end

  // checks
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ORDER_SLOTS)) else $error("count beyond slots");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sale_o.valid |-> !cmd_i.ready) else $error("result while idle");
  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(count_q) == CntW'(ORDER_SLOTS)) else $error("bad overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sale_o.valid && !sale_o.ready |=> sale_o.valid && $stable(sale_o.sale_amount) &&
    $stable(sale_o.last_sale)) else $error("word changed while waiting");

endmodule
